// File: hdl/three_point_dixon_water_fat_defines.svh
// Assertion macros for the three-point Dixon water/fat block.
// Included by the top level; depends on nothing else.
`ifndef THREE_POINT_DIXON_WATER_FAT_DEFINES_SVH
`define THREE_POINT_DIXON_WATER_FAT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define TPD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tpd check failed: same-cycle implication");

// Next-cycle implication, disabled while in reset.
`define TPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tpd check failed: next-cycle implication");

`endif

// File: hdl/tpd_pkg.sv
// Shared types, widths and constants for the three-point Dixon block.
// No dependencies; the module files refer to it by scoped names.
`default_nettype none

package tpd_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 28;

  // vectoring datapath, rotated echo, rotation datapath and angle widths
  localparam int VEC_W = SAMPLE_BITS + 3;
  localparam int ECHO_W = SAMPLE_BITS + 3;
  localparam int ROT_W = 34;
  localparam int ANG_W = 34;

  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'h26DD3B6A;

  // pipeline depths
  localparam int VEC_STAGES  = CORDIC_STEPS + 2;
  localparam int ROT_STAGES  = CORDIC_STEPS + 4;
  localparam int MRG_STAGES  = 5;
  localparam int PIPE_STAGES = VEC_STAGES + 1 + ROT_STAGES + MRG_STAGES;

  typedef enum logic [2:0] {
    REG_TE_RATIO_0       = 3'd0,
    REG_TE_RATIO_1       = 3'd1,
    REG_TE_RATIO_2       = 3'd2,
    REG_FAT_GAIN         = 3'd3,
    REG_WATER_COEF_MID   = 3'd4,
    REG_WATER_COEF_FIRST = 3'd5,
    REG_WATER_COEF_LAST  = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } coef_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] echo0_re;
    logic signed [SAMPLE_BITS-1:0] echo0_im;
    logic signed [SAMPLE_BITS-1:0] echo1_re;
    logic signed [SAMPLE_BITS-1:0] echo1_im;
    logic signed [SAMPLE_BITS-1:0] echo2_re;
    logic signed [SAMPLE_BITS-1:0] echo2_im;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] water_re;
    logic signed [SAMPLE_BITS-1:0] water_im;
    logic signed [SAMPLE_BITS-1:0] fat_re;
    logic signed [SAMPLE_BITS-1:0] fat_im;
  } out_beat_t;

  // arctangent of 2^-i, a full turn is 2^32
  function automatic logic [31:0] atan_turn(input int unsigned i);
    logic [31:0] t;
    unique case (i)
      0:  t = 32'h20000000;
      1:  t = 32'h12E4051E;
      2:  t = 32'h09FB385B;
      3:  t = 32'h051111D4;
      4:  t = 32'h028B0D43;
      5:  t = 32'h0145D7E1;
      6:  t = 32'h00A2F61E;
      7:  t = 32'h00517C55;
      8:  t = 32'h0028BE53;
      9:  t = 32'h00145F2F;
      10: t = 32'h000A2F98;
      11: t = 32'h000517CC;
      12: t = 32'h00028BE6;
      13: t = 32'h000145F3;
      14: t = 32'h0000A2FA;
      15: t = 32'h0000517D;
      16: t = 32'h000028BE;
      17: t = 32'h0000145F;
      18: t = 32'h00000A30;
      19: t = 32'h00000518;
      20: t = 32'h0000028C;
      21: t = 32'h00000146;
      22: t = 32'h000000A3;
      23: t = 32'h00000051;
      24: t = 32'h00000029;
      25: t = 32'h00000014;
      26: t = 32'h0000000A;
      27: t = 32'h00000005;
      default: t = 32'h00000000;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// File: hdl/three_point_dixon_water_fat.sv
// Top level of the three-point Dixon water/fat separation block.
// Depends on tpd_pkg, tpd_vector, tpd_rotate, tpd_merge and the defines header.
//
// Usage:
//   in_valid/in_ready/in_data carry one voxel per beat: three complex echoes.
//   out_valid/out_ready/out_data carry one water and fat estimate per beat.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write one register per beat:
//   0..2 TE ratios (Q16.16, low 32 bits of cfg_data), 3 fat gain, 4..6
//   water weights (packed Q8.24, real in the upper word). Other indexes are
//   dropped. cfg_ready is always high; write only while the block is idle.
// Timing:
//   An input beat passes the phase CORDIC, the echo phase difference, the
//   per-echo angle, rotation CORDIC and complex multiply, then the weighted
//   sums, rounding and saturation. Throughput is one voxel per cycle while
//   the output does not stall; the three echo lanes and both phase units
//   run side by side.
// Reset and stall:
//   rst is synchronous and clears the valid chain and the registers to their
//   defaults. The whole pipeline holds while a result waits in the output
//   register and out_ready is low; in_ready drops for those cycles only.
`default_nettype none
`include "three_point_dixon_water_fat_defines.svh"

module three_point_dixon_water_fat (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tpd_pkg::in_beat_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tpd_pkg::out_beat_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [63:0]                   cfg_data
);

  localparam int SB = tpd_pkg::SAMPLE_BITS;
  localparam int AB = tpd_pkg::ANGLE_BITS;
  localparam int EW = tpd_pkg::ECHO_W;
  localparam int VS = tpd_pkg::VEC_STAGES;
  localparam int PS = tpd_pkg::PIPE_STAGES;

  // configuration registers
  logic signed [31:0] te_ratio_0, te_ratio_1, te_ratio_2;
  tpd_pkg::coef_t     fat_gain, water_coef_mid, water_coef_first, water_coef_last;

  logic          en;
  logic [PS-1:0] vld;

  logic signed [AB-1:0] ph0, ph1;
  logic signed [SB-1:0] v0_re, v0_im, v1_re, v1_im;
  logic signed [SB-1:0] dl_re [0:VS-1];
  logic signed [SB-1:0] dl_im [0:VS-1];

  logic signed [AB:0]   delta;
  logic signed [SB-1:0] s0_re, s0_im, s1_re, s1_im, s2_re, s2_im;
  logic signed [EW-1:0] e0_re, e0_im, e1_re, e1_im, e2_re, e2_im;

  // advance everything unless a finished result is stuck at the output
  assign en        = !vld[PS-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[PS-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      te_ratio_0       <= 32'sd0;
      te_ratio_1       <= 32'sd65536;
      te_ratio_2       <= 32'sd131072;
      fat_gain         <= '0;
      water_coef_mid   <= '0;
      water_coef_first <= '0;
      water_coef_last  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tpd_pkg::REG_TE_RATIO_0:       te_ratio_0       <= signed'(cfg_data[31:0]);
        tpd_pkg::REG_TE_RATIO_1:       te_ratio_1       <= signed'(cfg_data[31:0]);
        tpd_pkg::REG_TE_RATIO_2:       te_ratio_2       <= signed'(cfg_data[31:0]);
        tpd_pkg::REG_FAT_GAIN:         fat_gain         <= cfg_data;
        tpd_pkg::REG_WATER_COEF_MID:   water_coef_mid   <= cfg_data;
        tpd_pkg::REG_WATER_COEF_FIRST: water_coef_first <= cfg_data;
        tpd_pkg::REG_WATER_COEF_LAST:  water_coef_last  <= cfg_data;
        default: ;
      endcase
    end
  end

  // phase of the first two echoes
  tpd_vector u_vec0 (
    .clk   (clk),
    .en    (en),
    .x_in  (in_data.echo0_re),
    .y_in  (in_data.echo0_im),
    .phase (ph0),
    .x_out (v0_re),
    .y_out (v0_im)
  );

  tpd_vector u_vec1 (
    .clk   (clk),
    .en    (en),
    .x_in  (in_data.echo1_re),
    .y_in  (in_data.echo1_im),
    .phase (ph1),
    .x_out (v1_re),
    .y_out (v1_im)
  );

  // third echo waits out the phase units
  always_ff @(posedge clk) begin
    if (en) begin
      dl_re[0] <= in_data.echo2_re;
      dl_im[0] <= in_data.echo2_im;
    end
  end

  for (genvar g = 1; g < VS; g++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) begin
        dl_re[g] <= dl_re[g-1];
        dl_im[g] <= dl_im[g-1];
      end
    end
  end

  // field term: plain difference, no unwrapping
  always_ff @(posedge clk) begin
    if (en) begin
      delta <= (AB + 1)'(ph1) - (AB + 1)'(ph0);
      s0_re <= v0_re;
      s0_im <= v0_im;
      s1_re <= v1_re;
      s1_im <= v1_im;
      s2_re <= dl_re[VS-1];
      s2_im <= dl_im[VS-1];
    end
  end

  // one rotation lane per echo
  tpd_rotate u_rot0 (
    .clk (clk), .en (en), .delta (delta), .ratio (te_ratio_0),
    .s_re (s0_re), .s_im (s0_im), .e_re (e0_re), .e_im (e0_im)
  );

  tpd_rotate u_rot1 (
    .clk (clk), .en (en), .delta (delta), .ratio (te_ratio_1),
    .s_re (s1_re), .s_im (s1_im), .e_re (e1_re), .e_im (e1_im)
  );

  tpd_rotate u_rot2 (
    .clk (clk), .en (en), .delta (delta), .ratio (te_ratio_2),
    .s_re (s2_re), .s_im (s2_im), .e_re (e2_re), .e_im (e2_im)
  );

  tpd_merge u_merge (
    .clk        (clk),
    .en         (en),
    .e0_re      (e0_re),
    .e0_im      (e0_im),
    .e1_re      (e1_re),
    .e1_im      (e1_im),
    .e2_re      (e2_re),
    .e2_im      (e2_im),
    .fat_gain   (fat_gain),
    .coef_mid   (water_coef_mid),
    .coef_first (water_coef_first),
    .coef_last  (water_coef_last),
    .result     (out_data)
  );

  // an accepted beat enters the valid chain
  `TPD_ASSERT_NEXT(a_fill, clk, rst, in_valid && in_ready, vld[0])
  // a stalled pipeline keeps every occupancy bit
  `TPD_ASSERT_NEXT(a_hold, clk, rst, !in_ready, $stable(vld))
  // a write to TE ratio 1 lands in its register
  `TPD_ASSERT_NEXT(a_cfg, clk, rst, cfg_valid && (cfg_index == tpd_pkg::REG_TE_RATIO_1), te_ratio_1 == signed'($past(cfg_data[31:0])))

endmodule

`default_nettype wire

// File: hdl/tpd_vector.sv
// Pipelined CORDIC vectoring unit: phase of one complex sample.
// Depends on tpd_pkg. Carries the sample alongside for later lanes.
`default_nettype none

module tpd_vector (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [tpd_pkg::SAMPLE_BITS-1:0] x_in,
  input  logic signed [tpd_pkg::SAMPLE_BITS-1:0] y_in,
  output logic signed [tpd_pkg::ANGLE_BITS-1:0]  phase,
  output logic signed [tpd_pkg::SAMPLE_BITS-1:0] x_out,
  output logic signed [tpd_pkg::SAMPLE_BITS-1:0] y_out
);

  localparam int SB = tpd_pkg::SAMPLE_BITS;
  localparam int AB = tpd_pkg::ANGLE_BITS;
  localparam int VW = tpd_pkg::VEC_W;
  localparam int N  = tpd_pkg::CORDIC_STEPS;

  logic signed [VW-1:0] vx [0:N];
  logic signed [VW-1:0] vy [0:N];
  logic        [31:0]   vz [0:N];
  logic                 zero [0:N];
  logic signed [SB-1:0] sx [0:N];
  logic signed [SB-1:0] sy [0:N];
  logic        [31:0]   zr;

  // fold the left half plane onto the right one
  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= (x_in == '0) && (y_in == '0);
      sx[0]   <= x_in;
      sy[0]   <= y_in;
      if (x_in < 0) begin
        vx[0] <= -VW'(x_in);
        vy[0] <= -VW'(y_in);
        vz[0] <= 32'h80000000;
      end else begin
        vx[0] <= VW'(x_in);
        vy[0] <= VW'(y_in);
        vz[0] <= 32'h00000000;
      end
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        zero[g+1] <= zero[g];
        sx[g+1]   <= sx[g];
        sy[g+1]   <= sy[g];
        if (!vy[g][VW-1]) begin
          vx[g+1] <= vx[g] + (vy[g] >>> g);
          vy[g+1] <= vy[g] - (vx[g] >>> g);
          vz[g+1] <= vz[g] + tpd_pkg::atan_turn(g);
        end else begin
          vx[g+1] <= vx[g] - (vy[g] >>> g);
          vy[g+1] <= vy[g] + (vx[g] >>> g);
          vz[g+1] <= vz[g] - tpd_pkg::atan_turn(g);
        end
      end
    end
  end

  // round the turn fraction to the phase format; wraps at +pi
  assign zr = vz[N] + (32'd1 << (31 - AB));

  always_ff @(posedge clk) begin
    if (en) begin
      phase <= zero[N] ? '0 : signed'(zr[31:32-AB]);
      x_out <= sx[N];
      y_out <= sy[N];
    end
  end

endmodule

`default_nettype wire

// File: hdl/tpd_rotate.sv
// One echo lane: angle from delta and TE ratio, CORDIC rotation, complex
// multiply of the sample. Depends on tpd_pkg.
`default_nettype none

module tpd_rotate (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [tpd_pkg::ANGLE_BITS:0]    delta,
  input  logic signed [31:0]                     ratio,
  input  logic signed [tpd_pkg::SAMPLE_BITS-1:0] s_re,
  input  logic signed [tpd_pkg::SAMPLE_BITS-1:0] s_im,
  output logic signed [tpd_pkg::ECHO_W-1:0]      e_re,
  output logic signed [tpd_pkg::ECHO_W-1:0]      e_im
);

  localparam int SB = tpd_pkg::SAMPLE_BITS;
  localparam int AB = tpd_pkg::ANGLE_BITS;
  localparam int EW = tpd_pkg::ECHO_W;
  localparam int RW = tpd_pkg::ROT_W;
  localparam int ZW = tpd_pkg::ANG_W;
  localparam int N  = tpd_pkg::CORDIC_STEPS;
  localparam int MW = AB + 1 + 32;
  localparam int PW = SB + RW;
  localparam logic signed [MW-1:0]  M_HALF = MW'(1) <<< 15;
  localparam logic signed [PW:0]    P_HALF = (PW + 1)'(1) <<< 29;

  logic signed [MW-1:0] m;
  logic signed [SB-1:0] m_re, m_im;
  logic signed [MW-1:0] m_rnd;
  logic        [AB-1:0] r_low;
  logic        [31:0]   ang;
  logic                 flip_c;

  logic signed [RW-1:0] cx [0:N];
  logic signed [RW-1:0] cy [0:N];
  logic signed [ZW-1:0] cz [0:N];
  logic                 flip [0:N];
  logic signed [SB-1:0] c_re [0:N];
  logic signed [SB-1:0] c_im [0:N];

  logic signed [RW-1:0] cosv, sinv;
  logic signed [PW-1:0] p_rc, p_is, p_rs, p_ic;
  logic signed [PW:0]   sum_re, sum_im;

  always_ff @(posedge clk) begin
    if (en) begin
      m    <= MW'(delta) * MW'(ratio);
      m_re <= s_re;
      m_im <= s_im;
    end
  end

  // round by 16, negate in angle units, then fold into [-pi/2, pi/2)
  always_comb begin
    m_rnd  = m + M_HALF;
    r_low  = m_rnd[16+AB-1:16];
    ang    = {-r_low, {(32 - AB){1'b0}}};
    flip_c = ang[31] ^ ang[30];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0]   <= RW'(signed'({1'b0, tpd_pkg::CORDIC_GAIN_Q30}));
      cy[0]   <= '0;
      cz[0]   <= ZW'(signed'({ang[31] ^ flip_c, ang[30:0]}));
      flip[0] <= flip_c;
      c_re[0] <= m_re;
      c_im[0] <= m_im;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        flip[g+1] <= flip[g];
        c_re[g+1] <= c_re[g];
        c_im[g+1] <= c_im[g];
        if (!cz[g][ZW-1]) begin
          cx[g+1] <= cx[g] - (cy[g] >>> g);
          cy[g+1] <= cy[g] + (cx[g] >>> g);
          cz[g+1] <= cz[g] - ZW'(tpd_pkg::atan_turn(g));
        end else begin
          cx[g+1] <= cx[g] + (cy[g] >>> g);
          cy[g+1] <= cy[g] - (cx[g] >>> g);
          cz[g+1] <= cz[g] + ZW'(tpd_pkg::atan_turn(g));
        end
      end
    end
  end

  assign cosv = flip[N] ? -cx[N] : cx[N];
  assign sinv = flip[N] ? -cy[N] : cy[N];

  always_ff @(posedge clk) begin
    if (en) begin
      p_rc <= PW'(c_re[N]) * PW'(cosv);
      p_is <= PW'(c_im[N]) * PW'(sinv);
      p_rs <= PW'(c_re[N]) * PW'(sinv);
      p_ic <= PW'(c_im[N]) * PW'(cosv);
    end
  end

  assign sum_re = (PW + 1)'(p_rc) - (PW + 1)'(p_is) + P_HALF;
  assign sum_im = (PW + 1)'(p_rs) + (PW + 1)'(p_ic) + P_HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      e_re <= signed'(sum_re[30 +: EW]);
      e_im <= signed'(sum_im[30 +: EW]);
    end
  end

endmodule

`default_nettype wire

// File: hdl/tpd_merge.sv
// Merging stage: fat and water weighted sums over the three rotated echoes,
// rounding and saturation into the output register. Depends on tpd_pkg.
`default_nettype none

module tpd_merge (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [tpd_pkg::ECHO_W-1:0] e0_re,
  input  logic signed [tpd_pkg::ECHO_W-1:0] e0_im,
  input  logic signed [tpd_pkg::ECHO_W-1:0] e1_re,
  input  logic signed [tpd_pkg::ECHO_W-1:0] e1_im,
  input  logic signed [tpd_pkg::ECHO_W-1:0] e2_re,
  input  logic signed [tpd_pkg::ECHO_W-1:0] e2_im,
  input  tpd_pkg::coef_t                    fat_gain,
  input  tpd_pkg::coef_t                    coef_mid,
  input  tpd_pkg::coef_t                    coef_first,
  input  tpd_pkg::coef_t                    coef_last,
  output tpd_pkg::out_beat_t                result
);

  localparam int SB = tpd_pkg::SAMPLE_BITS;
  localparam int EW = tpd_pkg::ECHO_W;
  localparam int DW = EW + 2;
  localparam int AW = 64;
  localparam int QW = AW - 24;
  localparam logic signed [AW-1:0] HALF = AW'(1) <<< 23;
  localparam logic signed [QW-1:0] QMAX = QW'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [QW-1:0] QMIN = -QMAX - QW'(1);

  function automatic logic signed [SB-1:0] sat(input logic signed [AW-1:0] v);
    logic signed [QW-1:0] q;
    logic signed [SB-1:0] r;
    q = v[AW-1:24];
    if (q > QMAX) begin
      r = SB'(QMAX);
    end else if (q < QMIN) begin
      r = SB'(QMIN);
    end else begin
      r = SB'(q);
    end
    return r;
  endfunction

  logic signed [DW-1:0] dr, di;
  logic signed [EW-1:0] d0r, d0i, d1r, d1i, d2r, d2i;
  logic signed [AW-1:0] a1, a2, a3, a4, b1, b2, b3, b4, c1, c2, c3, c4;
  logic signed [AW-1:0] f1, f2, f3, f4;
  logic signed [AW-1:0] wr_m, wr_f, wr_l, wi_m, wi_f, wi_l, fr_s, fi_s;
  logic signed [AW-1:0] wr_t, wi_t, fr_t, fi_t;

  // echo difference for fat: 2*E1 - E0 - E2
  always_ff @(posedge clk) begin
    if (en) begin
      dr  <= (DW'(e1_re) <<< 1) - DW'(e0_re) - DW'(e2_re);
      di  <= (DW'(e1_im) <<< 1) - DW'(e0_im) - DW'(e2_im);
      d0r <= e0_re;
      d0i <= e0_im;
      d1r <= e1_re;
      d1i <= e1_im;
      d2r <= e2_re;
      d2i <= e2_im;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= AW'(coef_mid.re) * AW'(d1r);
      a2 <= AW'(coef_mid.im) * AW'(d1i);
      a3 <= AW'(coef_mid.re) * AW'(d1i);
      a4 <= AW'(coef_mid.im) * AW'(d1r);
      b1 <= AW'(coef_first.re) * AW'(d0r);
      b2 <= AW'(coef_first.im) * AW'(d0i);
      b3 <= AW'(coef_first.re) * AW'(d0i);
      b4 <= AW'(coef_first.im) * AW'(d0r);
      c1 <= AW'(coef_last.re) * AW'(d2r);
      c2 <= AW'(coef_last.im) * AW'(d2i);
      c3 <= AW'(coef_last.re) * AW'(d2i);
      c4 <= AW'(coef_last.im) * AW'(d2r);
      f1 <= AW'(fat_gain.re) * AW'(dr);
      f2 <= AW'(fat_gain.im) * AW'(di);
      f3 <= AW'(fat_gain.re) * AW'(di);
      f4 <= AW'(fat_gain.im) * AW'(dr);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wr_m <= a1 - a2;
      wr_f <= b1 - b2;
      wr_l <= c1 - c2;
      wi_m <= a3 + a4;
      wi_f <= b3 + b4;
      wi_l <= c3 + c4;
      fr_s <= f1 - f2;
      fi_s <= f3 + f4;
    end
  end

  // sums are exact in 64 bits; add half an LSB of the output here
  always_ff @(posedge clk) begin
    if (en) begin
      wr_t <= wr_m - wr_f - wr_l + HALF;
      wi_t <= wi_m - wi_f - wi_l + HALF;
      fr_t <= fr_s + HALF;
      fi_t <= fi_s + HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.water_re <= sat(wr_t);
      result.water_im <= sat(wi_t);
      result.fat_re   <= sat(fr_t);
      result.fat_im   <= sat(fi_t);
    end
  end

endmodule

`default_nettype wire
